/* rtl/average_true_range_assert.svh */
// Assertion macros shared by the average true range checks.
`ifndef AVERAGE_TRUE_RANGE_ASSERT_SVH
`define AVERAGE_TRUE_RANGE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define ATR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ATR_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* rtl/atr_pkg.sv */
// Shared types and constants for the average true range block.
package atr_pkg;

	// Smoothing period after reset
	localparam int PERIOD_RESET = 14;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RANGE,
		ST_ACCUM,
		ST_SMOOTH,
		ST_SMLOAD,
		ST_DIV,
		ST_EMIT_ZERO,
		ST_EMIT_AVG
	} atr_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic range_step;
		logic accum_step;
		logic seed_load;
		logic smooth_step;
		logic smooth_load;
		logic emit_zero;
		logic emit_avg;
	} atr_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic first_bar;
		logic accumulate;
		logic seed_bar;
		logic div_busy;
		logic out_busy;
	} atr_status_t;

endpackage

/* rtl/average_true_range.sv */
// Top level of the Wilder average true range block.
//
//   channel  | transfer on           | contents
//   ---------+-----------------------+------------------------------------------
//   s_axis   | tvalid & tready       | one price bar (high, low, close, start)
//   m_axis   | tvalid & tready       | one average per bar, with valid flag
//   cfg      | cfg_wr_en             | smoothing period
//
// A bar is taken, then worked on alone until the block is idle again: a first bar passes range
// and emit, a warm-up bar range, sum and emit, the seed bar range, sum, division and emit, and a
// smoothing bar range, smoothing, divider load, division and emit; the serial divider yields
// one quotient bit a cycle. A result that is not taken holds the block in its emit state.
// One finished result waits in the output register while the next bar is taken.
// Reset is asynchronous and active low; the period returns to 14.
module average_true_range import atr_pkg::*; #(
	parameter int PRICE_BITS  = 32,
	parameter int PERIOD_BITS = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [PERIOD_BITS-1:0]                cfg_wr_data,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// bar_high, bar_low, bar_close, zero fill
	input  logic [((3*PRICE_BITS+7)/8)*8-1:0]     s_axis_tdata,
	// series_start
	input  logic [0:0]                            s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// range_average, zero fill
	output logic [((PRICE_BITS+7)/8)*8-1:0]       m_axis_tdata,
	// average_valid
	output logic [0:0]                            m_axis_tuser
);

	localparam int OUT_W = ((PRICE_BITS + 7) / 8) * 8;

	atr_cmd_t              cmd;
	atr_status_t           stat;
	logic [PRICE_BITS-1:0] range_average;
	logic                  average_valid;

	atr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	atr_datapath #(
		.PRICE_BITS  (PRICE_BITS),
		.PERIOD_BITS (PERIOD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.bar_high      (s_axis_tdata[PRICE_BITS-1:0]),
		.bar_low       (s_axis_tdata[2*PRICE_BITS-1:PRICE_BITS]),
		.bar_close     (s_axis_tdata[3*PRICE_BITS-1:2*PRICE_BITS]),
		.series_start  (s_axis_tuser[0]),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.range_average (range_average),
		.average_valid (average_valid)
	);

	assign m_axis_tdata    = OUT_W'(range_average);
	assign m_axis_tuser[0] = average_valid;

endmodule

/* rtl/atr_div.sv */
// Restoring serial divider, one quotient bit per cycle.
module atr_div import atr_pkg::*; #(
	parameter int DW = 43,
	parameter int VW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [VW:0]   rem_sh;
	logic [VW:0]   diff;
	logic          fits;

	// Trial subtract of the divisor from the shifted remainder
	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign diff   = rem_sh - {1'b0, divisor};
	assign fits   = rem_sh >= {1'b0, divisor};

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Shift the dividend through the remainder, collecting quotient bits
	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? diff[VW-1:0] : rem_sh[VW-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

/* rtl/atr_datapath.sv */
// Datapath: bar registers, true range, warm-up sum, smoothing and result register.
module atr_datapath import atr_pkg::*; #(
	parameter int PRICE_BITS  = 32,
	parameter int PERIOD_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  atr_cmd_t               cmd,
	output atr_status_t            stat,
	input  logic                   cfg_wr_en,
	input  logic [PERIOD_BITS-1:0] cfg_wr_data,
	input  logic [PRICE_BITS-1:0]  bar_high,
	input  logic [PRICE_BITS-1:0]  bar_low,
	input  logic [PRICE_BITS-1:0]  bar_close,
	input  logic                   series_start,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [PRICE_BITS-1:0]  range_average,
	output logic                   average_valid
);

	localparam int PW = PRICE_BITS;
	localparam int VW = PERIOD_BITS;
	localparam int SW = PW + VW;
	localparam int DW = SW + 1;

	logic [VW-1:0] period_cfg_q;
	logic [VW-1:0] period_q;
	logic [PW-1:0] high_q;
	logic [PW-1:0] low_q;
	logic [PW-1:0] close_q;
	logic          start_q;
	logic [PW-1:0] prev_close_q;
	logic [VW:0]   bars_q;
	logic [SW-1:0] sum_q;
	logic [PW-1:0] avg_q;
	logic [PW-1:0] tr_q;
	logic [SW-1:0] prod_q;
	logic          out_valid_q;
	logic [PW-1:0] out_avg_q;
	logic          out_flag_q;

	logic [PW-1:0] d_hl;
	logic [PW-1:0] d_hc;
	logic [PW-1:0] d_lc;
	logic [PW-1:0] tr_a;
	logic [PW-1:0] tr;
	logic [SW-1:0] sum_next;
	logic          div_load;
	logic [DW-1:0] div_dividend;
	logic          div_busy;
	logic [DW-1:0] div_quotient;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_cfg_q <= VW'(PERIOD_RESET);
		end else if (cfg_wr_en) begin
			period_cfg_q <= cfg_wr_data;
		end
	end

	// Capture the bar and the period in force for it; a zero period acts as one
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			high_q   <= bar_high;
			low_q    <= bar_low;
			close_q  <= bar_close;
			start_q  <= series_start;
			period_q <= (period_cfg_q == '0) ? VW'(1) : period_cfg_q;
		end
	end

	// True range: largest of high-low and the distances to the previous close
	assign d_hl = (high_q >= low_q) ? high_q - low_q : '0;
	assign d_hc = (high_q >= prev_close_q) ? high_q - prev_close_q : prev_close_q - high_q;
	assign d_lc = (low_q >= prev_close_q) ? low_q - prev_close_q : prev_close_q - low_q;
	assign tr_a = (d_hc > d_hl) ? d_hc : d_hl;
	assign tr   = (d_lc > tr_a) ? d_lc : tr_a;

	assign sum_next = sum_q + SW'(tr_q);

	// Series state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_close_q <= '0;
			bars_q       <= '0;
			sum_q        <= '0;
			avg_q        <= '0;
		end else begin
			if (cmd.range_step) begin
				prev_close_q <= close_q;
				if (stat.first_bar) begin
					bars_q <= (VW+1)'(1);
					sum_q  <= '0;
					avg_q  <= '0;
				end
			end
			if (cmd.accum_step) begin
				sum_q  <= sum_next;
				bars_q <= bars_q + (VW+1)'(1);
			end
			if (cmd.smooth_step) begin
				bars_q <= {1'b0, period_q} + (VW+1)'(1);
			end
			if (cmd.emit_avg) begin
				avg_q <= div_quotient[PW-1:0];
			end
		end
	end

	// Hold the true range and the smoothing product
	always_ff @(posedge clk) begin
		if (cmd.range_step) begin
			tr_q <= tr;
		end
		if (cmd.smooth_step) begin
			prod_q <= SW'(avg_q) * SW'(period_q - VW'(1));
		end
	end

	// Divide the seed sum or the smoothing numerator by the period
	assign div_load     = cmd.seed_load | cmd.smooth_load;
	assign div_dividend = cmd.seed_load ? DW'(sum_next) : DW'(prod_q) + DW'(tr_q);

	atr_div #(
		.DW(DW),
		.VW(VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.dividend (div_dividend),
		.divisor  (period_q),
		.busy     (div_busy),
		.quotient (div_quotient)
	);

	// Result register; a new result may replace one taken in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_zero || cmd.emit_avg) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_zero) begin
			out_avg_q  <= '0;
			out_flag_q <= 1'b0;
		end else if (cmd.emit_avg) begin
			out_avg_q  <= div_quotient[PW-1:0];
			out_flag_q <= 1'b1;
		end
	end

	// Status toward the controller
	assign stat.first_bar  = start_q || (bars_q == '0);
	assign stat.accumulate = bars_q <= {1'b0, period_q};
	assign stat.seed_bar   = bars_q == {1'b0, period_q};
	assign stat.div_busy   = div_busy;
	assign stat.out_busy   = out_valid_q && !out_ready;

	assign out_valid     = out_valid_q;
	assign range_average = out_avg_q;
	assign average_valid = out_flag_q;

endmodule

/* rtl/atr_ctrl.sv */
// Controller: sequences one bar through range, sum or smoothing, division and result.
module atr_ctrl import atr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  atr_status_t stat,
	output atr_cmd_t    cmd
);

	atr_state_t state_q;
	atr_state_t state_next;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_RANGE;
			end
			ST_RANGE: begin
				if (stat.first_bar) state_next = ST_EMIT_ZERO;
				else if (stat.accumulate) state_next = ST_ACCUM;
				else state_next = ST_SMOOTH;
			end
			ST_ACCUM: begin
				state_next = stat.seed_bar ? ST_DIV : ST_EMIT_ZERO;
			end
			ST_SMOOTH: begin
				state_next = ST_SMLOAD;
			end
			ST_SMLOAD: begin
				state_next = ST_DIV;
			end
			ST_DIV: begin
				if (!stat.div_busy) state_next = ST_EMIT_AVG;
			end
			ST_EMIT_ZERO, ST_EMIT_AVG: begin
				if (!stat.out_busy) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// Commands
	always_comb begin
		cmd         = '0;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_RANGE: begin
				cmd.range_step = 1'b1;
			end
			ST_ACCUM: begin
				cmd.accum_step = 1'b1;
				cmd.seed_load  = stat.seed_bar;
			end
			ST_SMOOTH: begin
				cmd.smooth_step = 1'b1;
			end
			ST_SMLOAD: begin
				cmd.smooth_load = 1'b1;
			end
			ST_DIV: begin
			end
			ST_EMIT_ZERO: begin
				cmd.emit_zero = !stat.out_busy;
			end
			ST_EMIT_AVG: begin
				cmd.emit_avg = !stat.out_busy;
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/atr_checker.sv */
// Port-level checks for the average true range block and their binding.
`include "average_true_range_assert.svh"

module atr_checker #(
	parameter int OUT_W = 32
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata,
	input logic [0:0]       m_axis_tuser
);

	// A stalled result holds its payload
	`ATR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	// A warm-up result carries a zero average
	`ATR_ASSERT_NEVER(a_warmup_zero, m_axis_tvalid && !m_axis_tuser[0] && m_axis_tdata != '0, "warm-up result with nonzero average")

	// One bar at a time: no input transfer right after one
	`ATR_ASSERT(a_one_bar, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while a bar is in work")

endmodule

bind average_true_range atr_checker #(
	.OUT_W($bits(m_axis_tdata))
) u_atr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

/* test/tb_average_true_range.sv */
// Testbench for the Wilder average true range block: random bars, own predictor, scoreboard.
module tb_average_true_range;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRICE_BITS    = 32;
	localparam int PERIOD_BITS   = 10;
	localparam int SETTLE_CYCLES = 60;
	localparam int STALL_LIMIT   = 4000;
	localparam int IDLE_PERCENT  = 16;

	// Expected averages, predicted from each accepted bar
	class atr_scoreboard;
		typedef struct {
			logic [PRICE_BITS-1:0] average;
			logic                  valid;
		} atr_result_t;

		atr_result_t                       expected_averages[$];
		logic [PERIOD_BITS-1:0]            period = PERIOD_BITS'(atr_pkg::PERIOD_RESET);
		logic [PRICE_BITS-1:0]             previous_close = '0;
		logic [PERIOD_BITS:0]              bars_seen = '0;
		logic [PRICE_BITS+PERIOD_BITS-1:0] range_sum = '0;
		logic [PRICE_BITS-1:0]             last_average = '0;
		int                                errors = 0;

		function int pending();
			return expected_averages.size();
		endfunction

		// Advance the series state by one bar and queue the average it yields
		function void note_bar(logic [PRICE_BITS-1:0] bar_high, logic [PRICE_BITS-1:0] bar_low,
				logic [PRICE_BITS-1:0] bar_close, logic series_start);
			logic [63:0] divisor;
			logic [63:0] true_range;
			logic [63:0] gap;
			logic [63:0] quotient;
			atr_result_t res;
			divisor = (period == 0) ? 64'd1 : 64'(period);
			res.average = '0;
			res.valid = 1'b0;
			if (series_start) begin
				previous_close = '0;
				bars_seen = '0;
				range_sum = '0;
				last_average = '0;
			end
			// First bar of a series only records its close
			if (bars_seen == 0) begin
				previous_close = bar_close;
				bars_seen = (PERIOD_BITS+1)'(1);
				expected_averages.push_back(res);
				return;
			end
			// A low above the high never wins the maximum
			true_range = (bar_high >= bar_low) ? 64'(bar_high - bar_low) : 64'd0;
			gap = (bar_high >= previous_close) ? 64'(bar_high - previous_close)
				: 64'(previous_close - bar_high);
			if (gap > true_range) true_range = gap;
			gap = (bar_low >= previous_close) ? 64'(bar_low - previous_close)
				: 64'(previous_close - bar_low);
			if (gap > true_range) true_range = gap;
			// Accumulate during warm-up, else smooth from the last average
			if (64'(bars_seen) <= divisor) begin
				range_sum = range_sum + true_range[PRICE_BITS+PERIOD_BITS-1:0];
				bars_seen = bars_seen + 1'b1;
				if (64'(bars_seen) == divisor + 1) begin
					quotient = 64'(range_sum) / divisor;
					last_average = quotient[PRICE_BITS-1:0];
					res.average = last_average;
					res.valid = 1'b1;
				end
			end else begin
				quotient = (64'(last_average) * (divisor - 1) + true_range) / divisor;
				last_average = quotient[PRICE_BITS-1:0];
				bars_seen = (PERIOD_BITS+1)'(divisor + 1);
				res.average = last_average;
				res.valid = 1'b1;
			end
			previous_close = bar_close;
			expected_averages.push_back(res);
		endfunction

		task report(string msg);
			errors++;
			$display("%0t ns mismatch: %s", $time, msg);
		endtask

		// Compare one output transfer with the oldest expectation
		task check_result(logic [PRICE_BITS-1:0] range_average, logic average_valid);
			atr_result_t want;
			if (expected_averages.size() == 0) begin
				report($sformatf("unexpected result average=%h valid=%b",
					range_average, average_valid));
			end else begin
				want = expected_averages.pop_front();
				if (range_average !== want.average)
					report($sformatf("range_average %h, expected %h",
						range_average, want.average));
				if (average_valid !== want.valid)
					report($sformatf("average_valid %b, expected %b",
						average_valid, want.valid));
			end
		endtask
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [PERIOD_BITS-1:0]  cfg_wr_data = '0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	// bar_high, bar_low, bar_close
	logic [3*PRICE_BITS-1:0] s_axis_tdata = '0;
	// series_start
	logic [0:0]              s_axis_tuser = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b1;
	// range_average
	logic [PRICE_BITS-1:0]   m_axis_tdata;
	// average_valid
	logic [0:0]              m_axis_tuser;

	atr_scoreboard           sb = new();
	int                      bars_sent = 0;
	int                      stall_cycles = 0;
	logic [PRICE_BITS-1:0]   price_level = 32'h0010_0000;
	logic                    calm;

	average_true_range #(
		.PRICE_BITS (PRICE_BITS),
		.PERIOD_BITS(PERIOD_BITS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Hold off idling on both sides over one stretch of bars
	assign calm = (bars_sent >= 900) && (bars_sent < 1200);

	// Stall the result side at random
	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser[0]);
	end

	// Drop the run when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Offer one bar, idling first at random, and note it once transferred
	task automatic send_bar(input logic [PRICE_BITS-1:0] bar_high,
			input logic [PRICE_BITS-1:0] bar_low, input logic [PRICE_BITS-1:0] bar_close,
			input logic series_start);
		while (!calm && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tdata <= {bar_close, bar_low, bar_high};
		s_axis_tuser <= series_start;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_bar(bar_high, bar_low, bar_close, series_start);
		bars_sent++;
	endtask

	// Stop sending and wait for every expected average
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Write the period once the block has gone idle
	task automatic configure(input logic [PERIOD_BITS-1:0] value);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_data <= value;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.period = value;
	endtask

	// Mostly plausible bars around a drifting level, some raw noise and extremes
	function automatic void make_bar(output logic [PRICE_BITS-1:0] bar_high,
			output logic [PRICE_BITS-1:0] bar_low, output logic [PRICE_BITS-1:0] bar_close);
		int unsigned kind;
		logic [PRICE_BITS-1:0] swap;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			bar_high = $urandom;
			bar_low = $urandom;
			bar_close = $urandom;
		end else if (kind < 15) begin
			bar_high = $urandom_range(0, 1) ? '1 : $urandom;
			bar_low = $urandom_range(0, 1) ? '0 : $urandom;
			bar_close = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? '1 : '0) : $urandom;
		end else begin
			price_level = price_level + $urandom_range(0, 2000) - 1000;
			bar_high = price_level + $urandom_range(0, 3000);
			bar_low = price_level - $urandom_range(0, 3000);
			bar_close = price_level - 1500 + $urandom_range(0, 3000);
			if (kind < 20) begin
				swap = bar_high;
				bar_high = bar_low;
				bar_low = swap;
			end
		end
	endfunction

	initial begin
		int periods[11] = '{2, 1, 0, 5, 1023, 3, 14, 9, 1, 30, 4};
		int bar_total;
		logic [PRICE_BITS-1:0] h, l, c;
		logic st;

		// Hold reset, then release at a clock edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed bars under the reset period: no start on the very first bar,
		// extremes, low above high, a restart, then enough bars to seed and smooth
		send_bar(32'd1000, 32'd800, 32'd900, 1'b0);
		send_bar(32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0);
		send_bar(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0);
		send_bar(32'h0, 32'h0, 32'h0, 1'b0);
		send_bar(32'd1200, 32'd1000, 32'd1100, 1'b1);
		send_bar(32'd1300, 32'd1100, 32'd1250, 1'b0);
		send_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 1'b0);
		send_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 1'b0);
		for (int i = 0; i < 14; i++) begin
			h = (i == 13) ? 32'hFFFF_FFFF : 32'h0001_0000 + i * 777;
			l = (i == 13) ? 32'h0 : h - i * 55;
			c = (i == 13) ? 32'hFFFF_FFFF : l + i;
			send_bar(h, l, c, 1'b0);
		end

		// Random phases; the series carries over period changes unless restarted
		foreach (periods[k]) begin
			configure(PERIOD_BITS'(periods[k]));
			bar_total = (periods[k] == 1023) ? 1100 : 60;
			for (int j = 0; j < bar_total; j++) begin
				make_bar(h, l, c);
				if (periods[k] == 1023)
					st = (j == 0);
				else
					st = ($urandom_range(0, 49) == 0);
				send_bar(h, l, c, st);
				if (k == 0 && j == 30)
					drain();
			end
		end

		// Let the last averages arrive, then a quiet tail
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
